@@ hdl/stack_language_tokenizer_core_defines.svh @@
// Assertion helpers for the checker of the tokenizer.
`ifndef STACK_LANGUAGE_TOKENIZER_CORE_DEFINES_SVH
`define STACK_LANGUAGE_TOKENIZER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tokenizer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tokenizer assertion failed");

`endif

@@ hdl/slt_pkg.sv @@
`default_nettype none

package slt_pkg;

	localparam int LINE_BITS_DEF   = 20;
	localparam int NUMBER_BITS_DEF = 32;
	localparam int KW_COUNT        = 6;
	localparam int WORD_LEN_BITS   = 9;

	// Token kinds.
	localparam logic [1:0] KIND_NUMBER  = 2'd0;
	localparam logic [1:0] KIND_INSTR   = 2'd1;
	localparam logic [1:0] KIND_UNKNOWN = 2'd2;

	// Instruction codes; these are also the keyword indexes.
	localparam logic [2:0] INSTR_PUSH  = 3'd0;
	localparam logic [2:0] INSTR_PLUS  = 3'd1;
	localparam logic [2:0] INSTR_MINUS = 3'd2;
	localparam logic [2:0] INSTR_MUL   = 3'd3;
	localparam logic [2:0] INSTR_DIV   = 3'd4;
	localparam logic [2:0] INSTR_RET   = 3'd5;

	// Characters of interest.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [2:0] {
		PH_SKIP   = 3'b001,
		PH_DIGITS = 3'b010,
		PH_DONE   = 3'b100
	} slt_phase_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic [2:0] code;
	} slt_tok_t;

	function automatic logic [2:0] kw_len(input logic [2:0] k);
		logic [2:0] len;
		case (k)
			INSTR_PUSH: len = 3'd4;
			INSTR_RET:  len = 3'd3;
			INSTR_PLUS, INSTR_MINUS, INSTR_MUL, INSTR_DIV: len = 3'd1;
			default:    len = 3'd0;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [1:0] p);
		logic [7:0] ch;
		ch = CH_NUL;
		case (k)
			INSTR_PUSH: begin
				case (p)
					2'd0:    ch = 8'h70;
					2'd1:    ch = 8'h75;
					2'd2:    ch = 8'h73;
					default: ch = 8'h68;
				endcase
			end
			INSTR_PLUS:  if (p == 2'd0) ch = CH_PLUS;
			INSTR_MINUS: if (p == 2'd0) ch = CH_MINUS;
			INSTR_MUL:   if (p == 2'd0) ch = CH_STAR;
			INSTR_DIV:   if (p == 2'd0) ch = CH_SLASH;
			INSTR_RET: begin
				case (p)
					2'd0:    ch = 8'h72;
					2'd1:    ch = 8'h65;
					2'd2:    ch = 8'h74;
					default: ch = CH_NUL;
				endcase
			end
			default: ch = CH_NUL;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

@@ hdl/slt_scan.sv @@
`default_nettype none

module slt_scan #(
	parameter int LINE_BITS   = slt_pkg::LINE_BITS_DEF,
	parameter int NUMBER_BITS = slt_pkg::NUMBER_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic [7:0]             char_byte,
	output slt_pkg::slt_tok_t           tok,
	output logic      [NUMBER_BITS-1:0] number_value,
	output logic      [LINE_BITS-1:0]   line_number
);
	import slt_pkg::*;

	logic [WORD_LEN_BITS-1:0] word_len_q, word_len_d;
	logic [KW_COUNT-1:0]      cand_q, cand_d;
	logic                     hash_q, hash_d;
	slt_phase_t               phase_q, phase_d;
	logic                     neg_q, neg_d;
	logic [NUMBER_BITS-1:0]   acc_q, acc_d;
	logic [LINE_BITS-1:0]     line_q, line_d;

	logic                   is_sep;
	logic                   is_digit;
	logic                   is_ws;
	logic [NUMBER_BITS-1:0] digit_val;
	logic                   found;

	assign is_sep    = (char_byte == CH_SPACE) || (char_byte == CH_LF) || (char_byte == CH_NUL);
	assign is_digit  = char_byte inside {[CH_ZERO:CH_NINE]};
	assign is_ws     = char_byte inside {CH_TAB, CH_VT, CH_FF, CH_CR};
	assign digit_val = NUMBER_BITS'(char_byte - CH_ZERO);

	always_comb begin
		word_len_d = word_len_q;
		cand_d     = cand_q;
		hash_d     = hash_q;
		phase_d    = phase_q;
		neg_d      = neg_q;
		acc_d      = acc_q;
		line_d     = line_q;
		if (!is_sep) begin
			if (word_len_q == '0 && char_byte == CH_HASH) begin
				hash_d = 1'b1;
			end else if (hash_q) begin
				case (phase_q)
					PH_SKIP: begin
						if (is_ws) begin
							phase_d = PH_SKIP;
						end else if (char_byte == CH_PLUS) begin
							phase_d = PH_DIGITS;
						end else if (char_byte == CH_MINUS) begin
							neg_d   = 1'b1;
							phase_d = PH_DIGITS;
						end else if (is_digit) begin
							acc_d   = digit_val;
							phase_d = PH_DIGITS;
						end else begin
							phase_d = PH_DONE;
						end
					end
					PH_DIGITS: begin
						if (is_digit) begin
							// Times ten as two shifts, wrapping at the accumulator width.
							acc_d = (acc_q << 3) + (acc_q << 1) + digit_val;
						end else begin
							phase_d = PH_DONE;
						end
					end
					default: phase_d = phase_q;
				endcase
			end
			for (int k = 0; k < KW_COUNT; k++) begin
				if (word_len_q >= WORD_LEN_BITS'(kw_len(3'(k))) ||
				    kw_char(3'(k), word_len_q[1:0]) != char_byte) begin
					cand_d[k] = 1'b0;
				end
			end
			if (word_len_q != '1) begin
				word_len_d = word_len_q + 1'b1;
			end
		end else begin
			word_len_d = '0;
			cand_d     = '1;
			hash_d     = 1'b0;
			phase_d    = PH_SKIP;
			neg_d      = 1'b0;
			acc_d      = '0;
			if (char_byte == CH_LF) begin
				if (line_q != '1) begin
					line_d = line_q + 1'b1;
				end
			end else if (char_byte == CH_NUL) begin
				line_d = LINE_BITS'(1);
			end
		end
	end

	// The token that a separator closes, from the state before it.
	always_comb begin
		tok.valid    = is_sep && (word_len_q != '0);
		tok.kind     = KIND_UNKNOWN;
		tok.code     = INSTR_PUSH;
		number_value = '0;
		found        = 1'b0;
		if (hash_q) begin
			tok.kind     = KIND_NUMBER;
			number_value = neg_q ? (~acc_q + 1'b1) : acc_q;
		end else begin
			for (int k = 0; k < KW_COUNT; k++) begin
				if (!found && cand_q[k] && word_len_q == WORD_LEN_BITS'(kw_len(3'(k)))) begin
					found    = 1'b1;
					tok.kind = KIND_INSTR;
					tok.code = 3'(k);
				end
			end
		end
	end

	assign line_number = line_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_len_q <= '0;
			cand_q     <= '1;
			hash_q     <= 1'b0;
			phase_q    <= PH_SKIP;
			neg_q      <= 1'b0;
			acc_q      <= '0;
			line_q     <= LINE_BITS'(1);
		end else if (en) begin
			word_len_q <= word_len_d;
			cand_q     <= cand_d;
			hash_q     <= hash_d;
			phase_q    <= phase_d;
			neg_q      <= neg_d;
			acc_q      <= acc_d;
			line_q     <= line_d;
		end
	end

endmodule

`default_nettype wire

@@ hdl/stack_language_tokenizer_core.sv @@
// Channel  Dir  Request content (tdata, lowest bit first)
// s_axis   in   char_byte[7:0]
// m_axis   out  token_kind[1:0], instr_code[2:0], number_value, line_number, zero fill
//
// One text byte is taken every cycle while m_axis does not stall; a byte waits in the
// input register, and a token is written to the output register as its separator leaves it.
// The word state updates as the byte leaves the input register, so each byte needs
// only the single pass through the scanner logic.
// arst_n clears the valid bits of both registers and the word state, and sets the line to 1.
// When m_axis stalls with a token held, s_axis_tready drops once the input register is full.
`default_nettype none

module stack_language_tokenizer_core #(
	parameter int LINE_BITS   = slt_pkg::LINE_BITS_DEF,
	parameter int NUMBER_BITS = slt_pkg::NUMBER_BITS_DEF,
	localparam int OUT_BITS   = 5 + NUMBER_BITS + LINE_BITS,
	localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [7:0]       s_axis_tdata,  // char_byte
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic      [OUT_W-1:0] m_axis_tdata   // token_kind, instr_code, number_value,
	                                             // line_number, zero fill
);
	import slt_pkg::*;

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   advance;
	slt_tok_t               tok;
	logic [NUMBER_BITS-1:0] value;
	logic [LINE_BITS-1:0]   line;
	logic                   out_valid_q;
	logic [OUT_BITS-1:0]    out_data_q;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	slt_scan #(
		.LINE_BITS   (LINE_BITS),
		.NUMBER_BITS (NUMBER_BITS)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (valid_s1 && advance),
		.char_byte    (byte_s1),
		.tok          (tok),
		.number_value (value),
		.line_number  (line)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && tok.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && tok.valid) begin
			out_data_q <= {line, value, tok.code, tok.kind};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(out_data_q);

endmodule

`default_nettype wire

@@ hdl/slt_checker.sv @@
`default_nettype none
`include "stack_language_tokenizer_core_defines.svh"

module slt_checker #(
	parameter int LINE_BITS   = slt_pkg::LINE_BITS_DEF,
	parameter int NUMBER_BITS = slt_pkg::NUMBER_BITS_DEF,
	localparam int OUT_BITS   = 5 + NUMBER_BITS + LINE_BITS,
	localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8,
	localparam int LINE_LO    = 5 + NUMBER_BITS
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_axis_tvalid,
	input wire logic             s_axis_tready,
	input wire logic [7:0]       s_axis_tdata,
	input wire logic             m_axis_tvalid,
	input wire logic             m_axis_tready,
	input wire logic [OUT_W-1:0] m_axis_tdata
);
	import slt_pkg::*;

	logic [1:0]           kind;
	logic [2:0]           code;
	logic [LINE_BITS-1:0] line;
	logic                 in_req;

	assign kind   = m_axis_tdata[1:0];
	assign code   = m_axis_tdata[4:2];
	assign line   = m_axis_tdata[LINE_LO +: LINE_BITS];
	assign in_req = s_axis_tvalid && s_axis_tready && (s_axis_tdata != CH_NUL);

	`SLT_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`SLT_ASSERT_IMP(a_kind_legal, clk, arst_n, m_axis_tvalid, kind == KIND_NUMBER || kind == KIND_INSTR || kind == KIND_UNKNOWN)
	`SLT_ASSERT_IMP(a_code_only_instr, clk, arst_n, m_axis_tvalid && kind != KIND_INSTR, code == INSTR_PUSH)
	`SLT_ASSERT_IMP(a_line_nonzero, clk, arst_n, m_axis_tvalid || in_req, m_axis_tvalid ? (line != '0) : 1'b1)

endmodule

bind stack_language_tokenizer_core slt_checker #(
	.LINE_BITS   (LINE_BITS),
	.NUMBER_BITS (NUMBER_BITS)
) u_slt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ dv/stack_language_tokenizer_core_test.sv @@
module stack_language_tokenizer_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import slt_pkg::*;

	localparam int LINE_W    = LINE_BITS_DEF;
	localparam int NUM_W     = NUMBER_BITS_DEF;
	localparam int VALUE_LSB = 5;
	localparam int LINE_LSB  = VALUE_LSB + NUM_W;
	localparam int FILL_LSB  = LINE_LSB + LINE_W;
	localparam int OUT_W     = ((FILL_LSB + 7) / 8) * 8;

	localparam logic [LINE_W-1:0]        LINE_TOP     = '1;
	localparam logic [WORD_LEN_BITS-1:0] WORD_LEN_TOP = '1;

	typedef struct packed {
		logic [1:0]        kind;
		logic [2:0]        code;
		logic [NUM_W-1:0]  value;
		logic [LINE_W-1:0] line;
	} token_t;

	logic             clk           = 1'b0;
	logic             arst_n        = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [7:0]       s_axis_tdata  = 8'h00;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	// Both sides run flat out while this is set.
	bit steady = 1'b0;
	int mismatch_count = 0;
	int bytes_sent = 0;

	token_t expected_tokens[$];

	// Own copy of the word and line state.
	logic [WORD_LEN_BITS-1:0] word_len;
	logic [KW_COUNT-1:0]      kw_alive;
	logic                     hash_lead;
	slt_phase_t               num_phase;
	logic                     num_neg;
	logic [NUM_W-1:0]         num_acc;
	logic [LINE_W-1:0]        line_cnt;

	stack_language_tokenizer_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		m_axis_tready <= steady || ($urandom_range(99) >= 23);
	end

	// Keyword spelling, first character in the top byte, unused bytes zero.
	function automatic logic [31:0] kw_spelling(input logic [2:0] k);
		case (k)
			INSTR_PUSH:  return "push";
			INSTR_PLUS:  return {"+", 24'h0};
			INSTR_MINUS: return {"-", 24'h0};
			INSTR_MUL:   return {"*", 24'h0};
			INSTR_DIV:   return {"/", 24'h0};
			INSTR_RET:   return {"ret", 8'h0};
			default:     return '0;
		endcase
	endfunction

	function automatic void clear_word();
		word_len  = '0;
		kw_alive  = '1;
		hash_lead = 1'b0;
		num_phase = PH_SKIP;
		num_neg   = 1'b0;
		num_acc   = '0;
	endfunction

	// Advances the word state by one accepted byte and queues the token it ends, if any.
	function automatic void tokenize_byte(input logic [7:0] c);
		logic [31:0] spell;
		int          len;
		int          pos;
		logic        digit;
		logic        blank;
		token_t      tok;
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		blank = (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
		if (c != CH_SPACE && c != CH_LF && c != CH_NUL) begin
			pos = int'(word_len);
			if (pos == 0 && c == CH_HASH) begin
				hash_lead = 1'b1;
			end else if (hash_lead) begin
				case (num_phase)
					PH_SKIP: begin
						if (!blank) begin
							if (c == CH_PLUS) begin
								num_phase = PH_DIGITS;
							end else if (c == CH_MINUS) begin
								num_neg   = 1'b1;
								num_phase = PH_DIGITS;
							end else if (digit) begin
								num_acc   = NUM_W'(c - CH_ZERO);
								num_phase = PH_DIGITS;
							end else begin
								num_phase = PH_DONE;
							end
						end
					end
					PH_DIGITS: begin
						if (digit) num_acc = NUM_W'(num_acc * 10 + NUM_W'(c - CH_ZERO));
						else num_phase = PH_DONE;
					end
					default: ;
				endcase
			end
			for (int k = 0; k < KW_COUNT; k++) begin
				spell = kw_spelling(k[2:0]);
				len = (spell[7:0] != 0) ? 4 : (spell[15:8] != 0) ? 3 :
				      (spell[23:16] != 0) ? 2 : 1;
				if (pos >= len || spell[31 - 8 * pos -: 8] != c) kw_alive[k] = 1'b0;
			end
			if (word_len != WORD_LEN_TOP) word_len++;
		end else begin
			if (word_len != 0) begin
				tok = '{kind: KIND_UNKNOWN, code: '0, value: '0, line: line_cnt};
				if (hash_lead) begin
					tok.kind  = KIND_NUMBER;
					tok.value = num_neg ? -num_acc : num_acc;
				end else begin
					// Descending, so the lowest matching keyword wins.
					for (int k = KW_COUNT - 1; k >= 0; k--) begin
						spell = kw_spelling(k[2:0]);
						len = (spell[7:0] != 0) ? 4 : (spell[15:8] != 0) ? 3 :
						      (spell[23:16] != 0) ? 2 : 1;
						if (kw_alive[k] && word_len == len) begin
							tok.kind = KIND_INSTR;
							tok.code = k[2:0];
						end
					end
				end
				expected_tokens.push_back(tok);
			end
			clear_word();
			if (c == CH_LF) begin
				if (line_cnt != LINE_TOP) line_cnt++;
			end else if (c == CH_NUL) begin
				line_cnt = LINE_W'(1);
			end
		end
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
	                               input logic [63:0] want);
		$display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, field, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : token_check
		token_t           want;
		logic [OUT_W-1:0] got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (expected_tokens.size() == 0) begin
				report_mismatch("token with none expected", 64'(got), '0);
			end else begin
				want = expected_tokens.pop_front();
				if (got[1:0] !== want.kind)
					report_mismatch("token_kind", 64'(got[1:0]), 64'(want.kind));
				if (got[4:2] !== want.code)
					report_mismatch("instr_code", 64'(got[4:2]), 64'(want.code));
				if (got[LINE_LSB-1:VALUE_LSB] !== want.value)
					report_mismatch("number_value", 64'(got[LINE_LSB-1:VALUE_LSB]),
					                64'(want.value));
				if (got[FILL_LSB-1:LINE_LSB] !== want.line)
					report_mismatch("line_number", 64'(got[FILL_LSB-1:LINE_LSB]),
					                64'(want.line));
				if (got[OUT_W-1:FILL_LSB] !== '0)
					report_mismatch("zero fill", 64'(got[OUT_W-1:FILL_LSB]), '0);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		// Each cycle is left idle with a chance of 23 in a hundred.
		while (!steady && $urandom_range(99) < 23) gap++;
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		tokenize_byte(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	task automatic drain_tokens();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] random_text_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (b == CH_SPACE || b == CH_LF || b == CH_NUL);
		return b;
	endfunction

	// One word of random content followed by one or two separators.
	task automatic send_random_word();
		logic [7:0] blanks [4] = '{CH_TAB, CH_VT, CH_FF, CH_CR};
		int pick;
		int n;
		pick = $urandom_range(99);
		if (pick < 30) begin
			case ($urandom_range(9))
				0: send_text("push");
				1: send_text("+");
				2: send_text("-");
				3: send_text("*");
				4: send_text("/");
				5: send_text("ret");
				6: send_text("pus");
				7: send_text("pushh");
				8: send_text("re");
				default: send_text("rets");
			endcase
		end else if (pick < 65) begin
			send_byte(CH_HASH);
			n = ($urandom_range(2) == 0) ? $urandom_range(3) : 0;
			repeat (n) send_byte(blanks[$urandom_range(3)]);
			case ($urandom_range(3))
				0: send_byte(CH_MINUS);
				1: send_byte(CH_PLUS);
				default: ;
			endcase
			n = ($urandom_range(9) == 0) ? $urandom_range(20, 10) : $urandom_range(10);
			repeat (n) send_byte(8'(CH_ZERO + $urandom_range(9)));
			if ($urandom_range(4) == 0) begin
				send_byte(random_text_byte());
				repeat ($urandom_range(3)) send_byte(8'(CH_ZERO + $urandom_range(9)));
			end
		end else if (pick < 85) begin
			repeat ($urandom_range(8, 1)) send_byte(random_text_byte());
		end else begin
			repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
		end
		repeat ($urandom_range(5) == 0 ? 2 : 1) begin
			case ($urandom_range(19))
				0:          send_byte(CH_NUL);
				1, 2, 3, 4: send_byte(CH_LF);
				default:    send_byte(CH_SPACE);
			endcase
		end
	endtask

	task automatic test_keywords();
		send_text("push +\n- * / ret ");
		send_text("pus pushh re rets ++ -- +x r p ");
		send_text("ret");
		send_byte(CH_NUL);
	endtask

	task automatic test_number_edges();
		send_text("#0 #4294967295 #4294967296 #-1 #-2147483648 #2147483648 ");
		send_text("# #+ #- #12ab34 #+-5 ##5 #x9 # 5 ");
		// Leading blanks before the sign are skipped; a blank after the sign ends it.
		send_byte(CH_HASH);
		send_byte(CH_TAB);
		send_byte(CH_VT);
		send_byte(CH_FF);
		send_byte(CH_CR);
		send_text("-12 #-");
		send_byte(CH_TAB);
		send_text("5\n");
	endtask

	task automatic test_line_tracking();
		send_text("a\n\n\nb\nret");
		send_byte(CH_NUL);
		send_text("push\n");
		send_byte(CH_NUL);
		send_byte(CH_NUL);
		send_text("#7 ");
	endtask

	task automatic test_long_words();
		send_text("push");
		repeat (516) send_byte("h");
		send_byte(CH_SPACE);
		send_text("#-");
		repeat (40) send_byte(8'(CH_ZERO + $urandom_range(9)));
		send_byte(CH_LF);
	endtask

	task automatic test_pause_for_results();
		repeat (10) send_random_word();
		drain_tokens();
		repeat (10) send_random_word();
	endtask

	task automatic test_random_text();
		int start;
		start  = bytes_sent;
		steady = 1'b1;
		while (bytes_sent - start < 200) send_random_word();
		steady = 1'b0;
		while (bytes_sent - start < 600) send_random_word();
	endtask

	initial begin
		clear_word();
		line_cnt = LINE_W'(1);
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		test_keywords();
		test_number_edges();
		test_line_tracking();
		test_long_words();
		test_pause_for_results();
		test_random_text();
		drain_tokens();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("stack_language_tokenizer_core_test: clean");
		end else begin
			$display("stack_language_tokenizer_core_test: errors");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("stack_language_tokenizer_core_test: errors");
		$finish;
	end

endmodule
